>>> design/assert_macros.svh
// assertion helpers for the checksum core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tcpc_pkg.sv
package tcpc_pkg;

   localparam int WORD_W   = 16;
   localparam int POS_W    = 4;
   localparam int BCOUNT_W = 2;
   localparam int HWORDS_W = 4;
   localparam int PROTO_W  = 8;
   localparam int ADDR_W   = 32;

   localparam logic [POS_W-1:0]    CSUM_WORD_POS = 4'd8;
   localparam logic [POS_W-1:0]    POS_SATURATE  = 4'd9;
   localparam logic [BCOUNT_W-1:0] BYTES_ODD     = 2'd1;

   localparam int QUEUE_DEPTH = 4;

   // one classified word handed from the front to the back
   typedef struct packed {
      logic              first;
      logic              last;
      logic [WORD_W-1:0] operand;
      logic              fault;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

>>> design/tcpc_front.sv
module tcpc_front
   import tcpc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                first_word,
   input  logic                last_word,
   input  logic [WORD_W-1:0]   data_word,
   input  logic [BCOUNT_W-1:0] byte_count,
   input  logic [ADDR_W-1:0]   src_addr,
   input  logic [ADDR_W-1:0]   dst_addr,
   input  logic [PROTO_W-1:0]  protocol_num,
   input  logic [WORD_W-1:0]   ip_total_length,
   input  logic [HWORDS_W-1:0] ip_header_words,
   output item_type            item
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             fault_ff, fault_in;

   logic [POS_W-1:0]  pos_eff;
   logic              fault_new;
   logic              fault_eff;
   logic [WORD_W-1:0] hbytes;
   logic [WORD_W-1:0] seglen;
   logic [WORD_W-1:0] masked;
   logic [WORD_W-1:0] word_val;
   logic [18:0]       sum_wide;
   logic [16:0]       fold1;
   logic [16:0]       fold2;

   always_comb begin
      pos_eff   = first_word ? '0 : pos_ff;
      hbytes    = {{(WORD_W-HWORDS_W-2){1'b0}}, ip_header_words, 2'b00};
      fault_new = hbytes > ip_total_length;
      seglen    = fault_new ? '0 : (ip_total_length - hbytes);
      fault_eff = first_word ? fault_new : fault_ff;
      masked    = (byte_count == BYTES_ODD) ? {data_word[15:8], 8'h00} : data_word;
      word_val  = (pos_eff == CSUM_WORD_POS) ? '0 : masked;

      // pseudo header and first word summed wide, then folded twice
      sum_wide = {3'b000, src_addr[31:16]} + {3'b000, src_addr[15:0]}
               + {3'b000, dst_addr[31:16]} + {3'b000, dst_addr[15:0]}
               + {11'b0, protocol_num} + {3'b000, seglen} + {3'b000, word_val};
      fold1 = {1'b0, sum_wide[15:0]} + {14'b0, sum_wide[18:16]};
      fold2 = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};

      item.first   = first_word;
      item.last    = last_word;
      item.operand = first_word ? fold2[15:0] : word_val;
      item.fault   = fault_eff;

      pos_in   = pos_ff;
      fault_in = fault_ff;
      if (accept) begin
         if (last_word) begin
            pos_in   = '0;
            fault_in = 1'b0;
         end else begin
            pos_in   = (pos_eff < POS_SATURATE) ? pos_eff + 1'b1 : pos_eff;
            fault_in = fault_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fault_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         fault_ff <= fault_in;
      end
   end

endmodule

>>> design/tcpc_queue.sv
module tcpc_queue
   import tcpc_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  item_type                   push_item,
   input  logic                       pop,
   output item_type                   head_item,
   output queue_status_type           status,
   output logic [$clog2(Depth+1)-1:0] count
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth+1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Depth - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Depth);

   item_type         mem_ff [Depth];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item        = mem_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.full      = count_ff == FULL_CNT;
   assign count            = count_ff;

endmodule

>>> design/tcpc_back.sv
module tcpc_back
   import tcpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  queue_status_type  status,
   input  item_type          head_item,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] checksum,
   output logic              length_error
);

   logic [WORD_W-1:0] acc_ff, acc_in;
   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] csum_ff, csum_in;
   logic              err_ff, err_in;

   logic [WORD_W-1:0] base;
   logic [WORD_W:0]   sum;
   logic [WORD_W-1:0] result;
   logic              out_free;

   always_comb begin
      out_free = !valid_ff || rsp_tready;
      pop      = status.not_empty && (!head_item.last || out_free);
      base     = head_item.first ? '0 : acc_ff;
      sum      = {1'b0, base} + {1'b0, head_item.operand};
      result   = sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, sum[WORD_W]};

      acc_in   = acc_ff;
      valid_in = valid_ff && !rsp_tready;
      csum_in  = csum_ff;
      err_in   = err_ff;
      if (pop) begin
         if (head_item.last) begin
            acc_in   = '0;
            valid_in = 1'b1;
            csum_in  = ~result;
            err_in   = head_item.fault;
         end else begin
            acc_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      csum_ff <= csum_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign checksum     = csum_ff;
   assign length_error = err_ff;

endmodule

>>> design/tcp_checksum_pseudo_header_core.sv
// TCP checksum over an IPv4 pseudo header and a segment streamed as big-endian 16-bit words,
// one word per request. The first word (tuser high) also carries the addresses, protocol, total
// length and header length; the segment length is total minus four times the header length,
// saturating to zero with length_error set. Word 8 counts as zero and an odd last byte is padded
// low. Words are taken at one per clock: the front folds the pseudo header and classifies each
// word in the accepting cycle, a short queue (QueueDepth entries) carries them to an
// end-around-carry accumulator, and the complemented sum is held in an output register on the
// request with tlast. The last word of a segment passes the queue and then, once the output is
// free, the output register before its result is valid; the input stalls only when the queue
// fills behind a stalled result.
`include "assert_macros.svh"

module tcp_checksum_pseudo_header_core
   import tcpc_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // data_word[15:0], byte_count[17:16], src_addr[49:18], dst_addr[81:50],
   // protocol_num[89:82], ip_total_length[105:90], ip_header_words[109:106], zero fill
   input  logic [111:0] req_tdata,
   // first_word
   input  logic         req_tuser,
   // last_word
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // checksum[15:0]
   output logic [15:0]  rsp_tdata,
   // length_error
   output logic         rsp_tuser
);

   logic                            req_accept;
   item_type                        front_item;
   item_type                        head_item;
   queue_status_type                queue_status;
   logic [$clog2(QueueDepth+1)-1:0] queue_count;
   logic                            pop;

   assign req_tready = !queue_status.full;
   assign req_accept = req_tvalid && req_tready;

   tcpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .first_word      (req_tuser),
      .last_word       (req_tlast),
      .data_word       (req_tdata[15:0]),
      .byte_count      (req_tdata[17:16]),
      .src_addr        (req_tdata[49:18]),
      .dst_addr        (req_tdata[81:50]),
      .protocol_num    (req_tdata[89:82]),
      .ip_total_length (req_tdata[105:90]),
      .ip_header_words (req_tdata[109:106]),
      .item            (front_item)
   );

   tcpc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status),
      .count     (queue_count)
   );

   tcpc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .status       (queue_status),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .checksum     (rsp_tdata),
      .length_error (rsp_tuser)
   );

   `ASSERT_CLK(a_queue_bound, clock, reset,
      queue_count <= ($clog2(QueueDepth+1))'(QueueDepth), "queue count beyond depth")
   `ASSERT_CLK(a_no_result_overwrite, clock, reset,
      (pop && head_item.last) |-> (!rsp_tvalid || rsp_tready),
      "result popped over a stalled result")
   `ASSERT_ALWAYS(a_reset_empty, clock,
      $past(reset) |-> (queue_count == '0 && !rsp_tvalid), "state not cleared by reset")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import tcpc_pkg::*;
();

   typedef struct {
      bit        first;
      bit        last;
      bit [15:0] word;
      bit [1:0]  bytes;
      bit [31:0] src;
      bit [31:0] dst;
      bit [7:0]  proto;
      bit [15:0] total;
      bit [3:0]  hwords;
   } seg_word_type;

   class checksum_tracker;
      bit [15:0] sum;
      bit [3:0]  pos;
      bit        fault;
      bit [16:0] pending_sums[$];   // {length_error, checksum}
      int        mismatches;

      function bit [15:0] fold(bit [15:0] a, bit [15:0] b);
         bit [16:0] s;
         s = a + b;
         return s[15:0] + {15'd0, s[16]};
      endfunction

      function void note_request(seg_word_type w);
         bit [15:0] hbytes;
         bit [15:0] seglen;
         if (w.first) begin
            hbytes = {10'd0, w.hwords, 2'b00};
            if (hbytes > w.total) begin
               seglen = 16'd0;
               fault  = 1'b1;
            end else begin
               seglen = w.total - hbytes;
               fault  = 1'b0;
            end
            sum = fold(16'd0, w.src[31:16]);
            sum = fold(sum, w.src[15:0]);
            sum = fold(sum, w.dst[31:16]);
            sum = fold(sum, w.dst[15:0]);
            sum = fold(sum, {8'd0, w.proto});
            sum = fold(sum, seglen);
            pos = 4'd0;
         end
         // checksum field position adds nothing
         if (pos != CSUM_WORD_POS) begin
            sum = fold(sum, (w.bytes == BYTES_ODD) ? {w.word[15:8], 8'h00} : w.word);
         end
         if (pos < POS_SATURATE) begin
            pos++;
         end
         if (w.last) begin
            pending_sums.push_back({fault, ~sum});
            sum   = 16'd0;
            pos   = 4'd0;
            fault = 1'b0;
         end
      endfunction

      function void check_response(bit [15:0] csum, bit err);
         bit [16:0] want;
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected response: checksum %h length_error %b", csum, err);
            end
         end else begin
            want = pending_sums.pop_front();
            if (want[15:0] !== csum || want[16] !== err) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response mismatch: expected checksum %h length_error %b, got %h %b",
                           want[15:0], want[16], csum, err);
               end
            end
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;
   logic         rsp_tuser;

   checksum_tracker tracker = new();
   int  tx_quiet = 0;
   int  rx_quiet = 0;
   int  sent = 0;
   bit  hold_pending = 1'b0;

   tcp_checksum_pseudo_header_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle count per request, with occasional runs of back-to-back traffic
   function automatic int draw_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet = $urandom_range(20, 60);
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic seg_word_type make_word(bit first, bit last, bit [15:0] word,
                                              bit [1:0] bytes, bit [31:0] src, bit [31:0] dst,
                                              bit [7:0] proto, bit [15:0] total,
                                              bit [3:0] hwords);
      seg_word_type w;
      w.first  = first;
      w.last   = last;
      w.word   = word;
      w.bytes  = bytes;
      w.src    = src;
      w.dst    = dst;
      w.proto  = proto;
      w.total  = total;
      w.hwords = hwords;
      return w;
   endfunction

   task automatic send_request(seg_word_type w);
      int gap;
      gap = draw_wait(tx_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, w.hwords, w.total, w.proto, w.dst, w.src, w.bytes, w.word};
      req_tuser  <= w.first;
      req_tlast  <= w.last;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(w);
      sent++;
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_sums.size() != 0) @(posedge clock);
   endtask

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // result side
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_pending) begin
            stall = 300;
            hold_pending = 1'b0;
         end else begin
            stall = draw_wait(rx_quiet);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // request side
   initial begin
      int        len;
      int        kind;
      bit        first;
      bit        last;
      bit [1:0]  bytes;
      bit [15:0] total;
      bit        hold_done;
      bit        pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // word with no first word straight after reset
      send_request(make_word(0, 1, 16'h1234, 2'd2, 0, 0, 0, 0, 0));
      // all fields but the byte count at maximum, first and last together
      send_request(make_word(1, 1, 16'hffff, 2'd2, 32'hffffffff, 32'hffffffff, 8'hff,
                             16'hffff, 4'hf));
      // header longer than total
      send_request(make_word(1, 1, 16'h0000, 2'd2, 0, 0, 0, 16'd0, 4'hf));
      // header equal to total, odd byte
      send_request(make_word(1, 1, 16'h00ff, BYTES_ODD, 32'h0a000001, 32'hc0a80001, 8'd6,
                             16'd60, 4'hf));
      // long segment across the checksum field and position saturation
      for (int i = 0; i < 12; i++) begin
         bytes = (i == 3) ? 2'd0 : (i == 5) ? 2'd3 : (i == 8 || i == 11) ? BYTES_ODD : 2'd2;
         send_request(make_word(i == 0, i == 11,
                                (i == 1 || i == 8) ? 16'hffff : (i == 2) ? 16'h0000 :
                                16'h8000 + 16'(i * 16'h1111),
                                bytes, 32'h80000001, 32'h7ffffffe, 8'd17, 16'd1500, 4'd5));
      end
      send_request(make_word(1, 0, 16'h0000, 2'd2, 0, 0, 0, 16'd20, 4'd5));
      send_request(make_word(0, 1, 16'hffff, BYTES_ODD, 0, 0, 0, 0, 0));
      // restart in the middle of a segment
      send_request(make_word(1, 0, 16'hbeef, 2'd2, 32'h01020304, 32'h05060708, 8'd6,
                             16'd100, 4'd5));
      send_request(make_word(1, 1, 16'hcafe, 2'd2, 32'h11223344, 32'h55667788, 8'd6,
                             16'd44, 4'd11));
      drain_responses();

      while (sent < 1520) begin
         if (!hold_done && sent >= 500) begin
            hold_pending = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && sent >= 1000) begin
            pause_done = 1'b1;
            drain_responses();
         end
         kind = $urandom_range(0, 9);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 10);
         for (int i = 0; i < len; i++) begin
            first = (i == 0);
            last  = (i == len - 1);
            // broken framing
            if (kind == 0) begin
               first = ($urandom_range(0, 3) == 0);
               last  = ($urandom_range(0, 3) == 0);
            end
            if (last && $urandom_range(0, 1) == 1) begin
               bytes = BYTES_ODD;
            end else if ($urandom_range(0, 7) == 0) begin
               bytes = 2'($urandom_range(0, 3));
            end else begin
               bytes = 2'd2;
            end
            total = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64)) :
                                                  16'($urandom_range(0, 65535));
            send_request(make_word(first, last, 16'($urandom), bytes, $urandom, $urandom,
                                   8'($urandom_range(0, 255)), total,
                                   4'($urandom_range(0, 15))));
         end
      end

      req_tvalid <= 1'b0;
      while (tracker.pending_sums.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_sums.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
